@@ rtl/mfcm_pkg.sv @@
// Package for the MS2 fragment cosine match core.
// Holds the sequencer states, action and register codes, and fixed field widths.
// No dependencies.
package mfcm_pkg;

  localparam int unsigned LIB_PEAKS_DEF = 64;
  localparam int unsigned EXP_PEAKS_DEF = 256;

  localparam int unsigned MZ_W    = 32;
  localparam int unsigned INT_W   = 24;
  localparam int unsigned RT_W    = 16;
  localparam int unsigned PPM_W   = 14;
  localparam int unsigned ABS_W   = 16;
  localparam int unsigned COS_W   = 14;
  localparam int unsigned MINSH_W = 7;
  localparam int unsigned LVL_W   = 3;
  localparam int unsigned SHO_W   = 7;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 16;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [ACT_W-1:0] ACT_LOAD_LIB = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_EXP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE  = 2'd2;

  localparam logic [CIDX_W-1:0] REG_PPM     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ABS     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MIN_COS = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MIN_SH  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_RT_TOL  = 3'd4;

  localparam logic [LVL_W-1:0] LVL_BOTH    = 3'd1;
  localparam logic [LVL_W-1:0] LVL_MS2     = 3'd2;
  localparam logic [LVL_W-1:0] LVL_RT      = 3'd3;
  localparam logic [LVL_W-1:0] LVL_NEITHER = 3'd4;

  localparam logic [COS_W-1:0] COS_FULL = 14'd10000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LIB_RD,
    ST_LIB_WAIT,
    ST_EXP_RD,
    ST_EXP_D,
    ST_EXP_CMP,
    ST_FRAG_END,
    ST_P2_CHK,
    ST_P2_RD,
    ST_P2_WAIT,
    ST_DIV_A,
    ST_LD_B,
    ST_DIV_B,
    ST_MUL_AB,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_SQ_A,
    ST_LD_SQB,
    ST_SQ_B,
    ST_MUL_P,
    ST_NUM,
    ST_DIV_S,
    ST_SCORE,
    ST_RT
  } state_t;

endpackage

@@ rtl/ms2_fragment_cosine_match_core.sv @@
// MS2 fragment cosine match core: peak stores, nearest-peak scan, cosine and level.
// Depends on mfcm_pkg.
// Compute: a compute item holds in_tready low through the fragment-by-peak compare loop
//   over the L by E loaded peaks and the bit-serial divider for each of the M matched
//   fragments and for the score; with an empty list it goes straight to the result.
// Throughput: one load per cycle; no item is taken while a compute runs.
// Reset: synchronous active-low rst_n clears counts, registers and handshakes;
//   peak stores are not cleared and read only below the counts.
module ms2_fragment_cosine_match_core
  import mfcm_pkg::*;
#(
  parameter int unsigned LIB_PEAKS = LIB_PEAKS_DEF,
  parameter int unsigned EXP_PEAKS = EXP_PEAKS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // peak_mz[31:0], peak_intensity[55:32], measured_rt[71:56], reference_rt[87:72]
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]        in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // ident_level[2:0], shared_count[9:3], cosine_score[23:10],
  // spectrum_matched[24], time_matched[25], zero[31:26]
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CDAT_W-1:0]       cfg_data
);

  localparam int unsigned LIB_CW = $clog2(LIB_PEAKS + 1);
  localparam int unsigned EXP_CW = $clog2(EXP_PEAKS + 1);
  localparam int unsigned LIB_AW = (LIB_PEAKS > 1) ? $clog2(LIB_PEAKS) : 1;
  localparam int unsigned EXP_AW = (EXP_PEAKS > 1) ? $clog2(EXP_PEAKS) : 1;
  localparam int unsigned SHC_W  = (LIB_CW > MINSH_W) ? LIB_CW : MINSH_W;
  localparam int unsigned NRM_W  = 17;
  localparam int unsigned MAG_W  = 2 * NRM_W + LIB_CW;
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned DEN_W  = 48;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned WPR_W  = 56;
  localparam logic [WPR_W-1:0] TEN7 = WPR_W'(10000000);
  localparam logic [NUM_W-1:0] SCALE = NUM_W'(20000);
  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [SHC_W-1:0] SH_SAT = SHC_W'(127);

  state_t state_r, state_nxt;

  logic [LIB_CW-1:0] lib_count_r, z_r, shared_r;
  logic [EXP_CW-1:0] exp_count_r, k_r;
  logic [PPM_W-1:0]   ppm_r;
  logic [ABS_W-1:0]   abs_r;
  logic [COS_W-1:0]   min_cos_r;
  logic [MINSH_W-1:0] min_sh_r;
  logic [RT_W-1:0]    rt_tol_r;

  logic [MZ_W-1:0]  lib_mz_mem [LIB_PEAKS];
  logic [INT_W-1:0] lib_int_mem [LIB_PEAKS];
  logic [MZ_W-1:0]  exp_mz_mem [EXP_PEAKS];
  logic [INT_W-1:0] exp_int_mem [EXP_PEAKS];
  logic [INT_W:0]   match_mem [LIB_PEAKS];
  logic [MZ_W-1:0]  lib_mz_q, exp_mz_q;
  logic [INT_W-1:0] lib_int_q, exp_int_q;
  logic [INT_W:0]   match_q;

  logic [RT_W-1:0]  mrt_r, rrt_r;
  logic             lists_r;
  logic [MZ_W-1:0]  m_r, d_r, best_d_r;
  logic [WPR_W-1:0] mppm_r;
  logic [INT_W-1:0] lint_r, eint_r, best_int_r, max_db_r, max_ex_r;
  logic             found_r;
  logic [NRM_W-1:0] a_r;
  logic [MAG_W-1:0] dot_r, ma_r, mb_r;
  logic [31:0]      sa_r;
  logic [WPR_W-1:0] p_r;
  logic [COS_W-1:0] score_r;

  logic [NUM_W-1:0] div_num_r, div_q_r;
  logic [DEN_W-1:0] div_den_r;
  logic [DEN_W:0]   div_rem_r;
  logic [5:0]       div_cnt_r;
  logic [SQ_W-1:0]  sq_v_r, sq_res_r, sq_bit_r;

  logic             out_valid_r;
  logic [LVL_W-1:0] o_lvl_r;
  logic [SHO_W-1:0] o_sh_r;
  logic [COS_W-1:0] o_cos_r;
  logic             o_spec_r, o_time_r;

  logic in_acc;
  logic last_k, last_z;
  logic in_win, better;
  logic [MZ_W-1:0] d_c;
  logic [DEN_W:0]  div_sh;
  logic            div_ge;
  logic [SQ_W-1:0] sq_sum;
  logic            sq_ge;
  logic [NRM_W-1:0] b_c;
  logic [31:0]     mul_x, mul_y;
  logic [63:0]     mul_p;
  logic [RT_W-1:0] rt_d;
  logic            rt_ok, ms2;
  logic [SHC_W-1:0] sh_ext;

  assign in_acc = in_tvalid && in_tready;
  assign last_k = (k_r + EXP_CW'(1)) == exp_count_r;
  assign last_z = (z_r + LIB_CW'(1)) == lib_count_r;

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
    out_tvalid = out_valid_r;
    out_tdata = {6'd0, o_time_r, o_spec_r, o_cos_r, o_sh_r, o_lvl_r};
  end

  // Datapath arithmetic shared by the sequencer.
  always_comb begin
    d_c = (exp_mz_q > m_r) ? (exp_mz_q - m_r) : (m_r - exp_mz_q);
    in_win = ({16'd0, d_r} <= {32'd0, abs_r}) ||
             ((WPR_W'(d_r) * TEN7) <= mppm_r);
    better = in_win && (!found_r || (d_r < best_d_r));
    div_sh = {div_rem_r[DEN_W-1:0], div_num_r[NUM_W-1]};
    div_ge = div_sh >= {1'b0, div_den_r};
    sq_sum = sq_res_r + sq_bit_r;
    sq_ge  = sq_v_r >= sq_sum;
    b_c    = div_q_r[NRM_W-1:0];
    mul_x  = 32'd0;
    mul_y  = 32'd0;
    case (state_r)
      ST_MUL_AB: begin
        mul_x = 32'(a_r);
        mul_y = 32'(b_c);
      end
      ST_MUL_AA: begin
        mul_x = 32'(a_r);
        mul_y = 32'(a_r);
      end
      ST_MUL_BB: begin
        mul_x = 32'(b_c);
        mul_y = 32'(b_c);
      end
      ST_MUL_P: begin
        mul_x = sa_r;
        mul_y = sq_res_r[31:0];
      end
      default: begin
        mul_x = 32'd0;
        mul_y = 32'd0;
      end
    endcase
    mul_p  = 64'(mul_x) * 64'(mul_y);
    rt_d   = (mrt_r > rrt_r) ? (mrt_r - rrt_r) : (rrt_r - mrt_r);
    rt_ok  = (rrt_r != '0) && (rt_d <= rt_tol_r);
    sh_ext = SHC_W'(shared_r);
    ms2    = lists_r && ((sh_ext >= SHC_W'(min_sh_r)) || (score_r >= min_cos_r));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == ACT_COMPUTE) begin
          if (lib_count_r != '0 && exp_count_r != '0) state_nxt = ST_LIB_RD;
          else state_nxt = ST_RT;
        end
      end
      ST_LIB_RD:   state_nxt = ST_LIB_WAIT;
      ST_LIB_WAIT: state_nxt = ST_EXP_RD;
      ST_EXP_RD:   state_nxt = ST_EXP_D;
      ST_EXP_D:    state_nxt = ST_EXP_CMP;
      ST_EXP_CMP:  state_nxt = last_k ? ST_FRAG_END : ST_EXP_RD;
      ST_FRAG_END: state_nxt = last_z ? ST_P2_CHK : ST_LIB_RD;
      ST_P2_CHK: begin
        if (shared_r == '0 || max_db_r == '0 || max_ex_r == '0) state_nxt = ST_RT;
        else state_nxt = ST_P2_RD;
      end
      ST_P2_RD: state_nxt = ST_P2_WAIT;
      ST_P2_WAIT: begin
        if (match_q[INT_W]) state_nxt = ST_DIV_A;
        else if (last_z) state_nxt = ST_SQ_A;
        else state_nxt = ST_P2_RD;
      end
      ST_DIV_A:  state_nxt = (div_cnt_r == DIV_LAST) ? ST_LD_B : ST_DIV_A;
      ST_LD_B:   state_nxt = ST_DIV_B;
      ST_DIV_B:  state_nxt = (div_cnt_r == DIV_LAST) ? ST_MUL_AB : ST_DIV_B;
      ST_MUL_AB: state_nxt = ST_MUL_AA;
      ST_MUL_AA: state_nxt = ST_MUL_BB;
      ST_MUL_BB: state_nxt = last_z ? ST_SQ_A : ST_P2_RD;
      ST_SQ_A:   state_nxt = sq_bit_r[0] ? ST_LD_SQB : ST_SQ_A;
      ST_LD_SQB: state_nxt = ST_SQ_B;
      ST_SQ_B:   state_nxt = sq_bit_r[0] ? ST_MUL_P : ST_SQ_B;
      ST_MUL_P:  state_nxt = ST_NUM;
      ST_NUM:    state_nxt = (p_r == '0) ? ST_RT : ST_DIV_S;
      ST_DIV_S:  state_nxt = (div_cnt_r == DIV_LAST) ? ST_SCORE : ST_DIV_S;
      ST_SCORE:  state_nxt = ST_RT;
      ST_RT:     state_nxt = out_valid_r ? ST_RT : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == ACT_LOAD_LIB && lib_count_r < LIB_CW'(LIB_PEAKS)) begin
      lib_mz_mem[lib_count_r[LIB_AW-1:0]]  <= in_tdata[31:0];
      lib_int_mem[lib_count_r[LIB_AW-1:0]] <= in_tdata[55:32];
    end
    if (in_acc && in_tuser == ACT_LOAD_EXP && exp_count_r < EXP_CW'(EXP_PEAKS)) begin
      exp_mz_mem[exp_count_r[EXP_AW-1:0]]  <= in_tdata[31:0];
      exp_int_mem[exp_count_r[EXP_AW-1:0]] <= in_tdata[55:32];
    end
    if (state_r == ST_FRAG_END) match_mem[z_r[LIB_AW-1:0]] <= {found_r, best_int_r};
    lib_mz_q  <= lib_mz_mem[z_r[LIB_AW-1:0]];
    lib_int_q <= lib_int_mem[z_r[LIB_AW-1:0]];
    match_q   <= match_mem[z_r[LIB_AW-1:0]];
    exp_mz_q  <= exp_mz_mem[k_r[EXP_AW-1:0]];
    exp_int_q <= exp_int_mem[k_r[EXP_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppm_r     <= '0;
      abs_r     <= '0;
      min_cos_r <= '0;
      min_sh_r  <= '0;
      rt_tol_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PPM:     ppm_r     <= cfg_data[PPM_W-1:0];
        REG_ABS:     abs_r     <= cfg_data[ABS_W-1:0];
        REG_MIN_COS: min_cos_r <= cfg_data[COS_W-1:0];
        REG_MIN_SH:  min_sh_r  <= cfg_data[MINSH_W-1:0];
        REG_RT_TOL:  rt_tol_r  <= cfg_data[RT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lib_count_r <= '0;
      exp_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (in_acc && in_tuser == ACT_LOAD_LIB && lib_count_r < LIB_CW'(LIB_PEAKS))
        lib_count_r <= lib_count_r + LIB_CW'(1);
      if (in_acc && in_tuser == ACT_LOAD_EXP && exp_count_r < EXP_CW'(EXP_PEAKS))
        exp_count_r <= exp_count_r + EXP_CW'(1);
      if (state_r == ST_RT && !out_valid_r) begin
        out_valid_r <= 1'b1;
        lib_count_r <= '0;
        exp_count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        mrt_r    <= in_tdata[71:56];
        rrt_r    <= in_tdata[87:72];
        lists_r  <= (lib_count_r != '0) && (exp_count_r != '0);
        z_r      <= '0;
        k_r      <= '0;
        shared_r <= '0;
        score_r  <= '0;
        max_db_r <= '0;
        max_ex_r <= '0;
        dot_r    <= '0;
        ma_r     <= '0;
        mb_r     <= '0;
      end
      ST_LIB_WAIT: begin
        m_r     <= lib_mz_q;
        lint_r  <= lib_int_q;
        mppm_r  <= WPR_W'(64'(lib_mz_q) * 64'(ppm_r));
        found_r <= 1'b0;
        k_r     <= '0;
      end
      ST_EXP_D: begin
        d_r    <= d_c;
        eint_r <= exp_int_q;
      end
      ST_EXP_CMP: begin
        if (better) begin
          found_r    <= 1'b1;
          best_d_r   <= d_r;
          best_int_r <= eint_r;
        end
        k_r <= k_r + EXP_CW'(1);
      end
      ST_FRAG_END: begin
        if (found_r) begin
          shared_r <= shared_r + LIB_CW'(1);
          if (lint_r > max_db_r) max_db_r <= lint_r;
          if (best_int_r > max_ex_r) max_ex_r <= best_int_r;
        end
        z_r <= last_z ? '0 : z_r + LIB_CW'(1);
      end
      ST_P2_WAIT: begin
        div_num_r <= NUM_W'({lib_int_q, 16'd0});
        div_den_r <= DEN_W'(max_db_r);
        div_rem_r <= '0;
        div_cnt_r <= '0;
        if (!match_q[INT_W]) z_r <= z_r + LIB_CW'(1);
        if (!match_q[INT_W] && last_z) begin
          sq_v_r   <= SQ_W'({ma_r, 16'd0});
          sq_res_r <= '0;
          sq_bit_r <= SQ_W'(1) << 62;
        end
      end
      ST_DIV_A, ST_DIV_B, ST_DIV_S: begin
        div_rem_r <= div_ge ? (div_sh - {1'b0, div_den_r}) : div_sh;
        div_q_r   <= {div_q_r[NUM_W-2:0], div_ge};
        div_num_r <= {div_num_r[NUM_W-2:0], 1'b0};
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      ST_LD_B: begin
        a_r       <= div_q_r[NRM_W-1:0];
        div_num_r <= NUM_W'({match_q[INT_W-1:0], 16'd0});
        div_den_r <= DEN_W'(max_ex_r);
        div_rem_r <= '0;
        div_cnt_r <= '0;
      end
      ST_MUL_AB: dot_r <= dot_r + MAG_W'(mul_p);
      ST_MUL_AA: ma_r  <= ma_r + MAG_W'(mul_p);
      ST_MUL_BB: begin
        mb_r <= mb_r + MAG_W'(mul_p);
        z_r  <= z_r + LIB_CW'(1);
        if (last_z) begin
          sq_v_r   <= SQ_W'({ma_r, 16'd0});
          sq_res_r <= '0;
          sq_bit_r <= SQ_W'(1) << 62;
        end
      end
      ST_SQ_A, ST_SQ_B: begin
        if (sq_ge) begin
          sq_v_r   <= sq_v_r - sq_sum;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      ST_LD_SQB: begin
        sa_r     <= sq_res_r[31:0];
        sq_v_r   <= SQ_W'({mb_r, 16'd0});
        sq_res_r <= '0;
        sq_bit_r <= SQ_W'(1) << 62;
      end
      ST_MUL_P: p_r <= WPR_W'(mul_p >> 16);
      ST_NUM: begin
        div_num_r <= NUM_W'(dot_r) * SCALE + NUM_W'(p_r);
        div_den_r <= DEN_W'({p_r, 1'b0});
        div_rem_r <= '0;
        div_cnt_r <= '0;
      end
      ST_SCORE: begin
        if (div_q_r > NUM_W'(COS_FULL)) score_r <= COS_FULL;
        else score_r <= div_q_r[COS_W-1:0];
      end
      ST_RT: begin
        if (!out_valid_r) begin
          o_sh_r   <= (sh_ext > SH_SAT) ? SHO_W'(127) : SHO_W'(sh_ext);
          o_cos_r  <= score_r;
          o_spec_r <= ms2;
          o_time_r <= rt_ok;
          if (rt_ok && ms2) o_lvl_r <= LVL_BOTH;
          else if (ms2) o_lvl_r <= LVL_MS2;
          else if (rt_ok) o_lvl_r <= LVL_RT;
          else o_lvl_r <= LVL_NEITHER;
        end
      end
      default: ;
    endcase
  end

  a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lib_count_r <= LIB_CW'(LIB_PEAKS)) && (exp_count_r <= EXP_CW'(EXP_PEAKS)))
    else $error("peak count beyond capacity");

  a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (lib_count_r == '0) && (exp_count_r == '0))
    else $error("peak lists not cleared with result");

  a_level_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ((o_lvl_r == LVL_BOTH) == (o_spec_r && o_time_r)) &&
                           ((o_lvl_r == LVL_NEITHER) == (!o_spec_r && !o_time_r)))
    else $error("id level disagrees with match flags");

  a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_cos_r <= COS_FULL))
    else $error("cosine score above full scale");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input taken during compute");

endmodule
